### rtl/complete_tree_value_table_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the complete tree value table
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMPLETE_TREE_VALUE_TABLE_CORE_ASSERT_SVH
`define COMPLETE_TREE_VALUE_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define CTVT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ctvt_pkg.sv
// ----------------------------------------------------------------------------
// ctvt_pkg
// Shared types and constants of the complete tree value table.
// ----------------------------------------------------------------------------
package ctvt_pkg;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int VALUE_IN_W = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 6;
    localparam int COUNT_W    = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_DEL_SCAN,
        S_SRCH_CMP,
        S_SRCH_UP,
        S_DONE
    } t_state;

endpackage

### rtl/ctvt_ram.sv
// ----------------------------------------------------------------------------
// ctvt_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ctvt_ram #(
    parameter int DEPTH = ctvt_pkg::DEF_CAPACITY,
    parameter int AW    = 6,
    parameter int DW    = ctvt_pkg::DEF_VALUE_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/complete_tree_value_table_core.sv
// ----------------------------------------------------------------------------
// complete_tree_value_table_core
// Complete binary tree of signed values kept in level order in a RAM.
//
// Input channel (i_in_valid / o_in_ready): one command per transfer,
//   i_cmd = insert, delete or search, i_value = operand.
// Output channel (o_out_valid / i_out_ready): one result per command,
//   o_status, o_position, o_count_after.
// One command is processed at a time; o_in_ready is high only when idle.
// Work done per command, with n entries stored:
//   insert, unused code, or empty table: handled in the dispatch state
//   delete: linear scan of all n entries in the RAM, one entry per cycle; the last
//     entry is captured on the final scan read and written back at once
//   search: preorder walk of at most n nodes, one RAM read per visited node
//     plus a step per level when climbing back toward the root
// Another command may be taken while a finished result waits in the output
// register; if the receiver stalls, the next result is held until then.
// Reset empties the table (count to zero); RAM contents are not cleared.
// ----------------------------------------------------------------------------
module complete_tree_value_table_core #(
    parameter int CAPACITY    = ctvt_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = ctvt_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [ctvt_pkg::CMD_W-1:0]            i_cmd,
    input  logic signed [ctvt_pkg::VALUE_IN_W-1:0] i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [ctvt_pkg::STATUS_W-1:0]         o_status,
    output logic [ctvt_pkg::POS_W-1:0]            o_position,
    output logic [ctvt_pkg::COUNT_W-1:0]          o_count_after
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 1;
    localparam int PW = ctvt_pkg::POS_W;
    localparam int OW = ctvt_pkg::COUNT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    ctvt_pkg::t_state  r_state, n_state;
    logic [ctvt_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [VALUE_WIDTH-1:0]     r_val, n_val;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_hit, n_hit;
    logic              r_found, n_found;
    ctvt_pkg::t_status r_res_status, n_res_status;
    logic [IW-1:0]     r_res_pos, n_res_pos;

    logic              r_out_valid;
    ctvt_pkg::t_status r_out_status;
    logic [IW-1:0]     r_out_pos;
    logic [CW-1:0]     r_out_count;

    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [VALUE_WIDTH-1:0] rd_data;

    logic          w_match;
    logic          w_last;
    logic [XW-1:0] w_child_x;
    logic          w_has_child;
    logic          w_climb;
    logic [IW-1:0] w_parent;
    logic [IW-1:0] w_del_hit;
    logic          w_out_free;

    ctvt_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .DW    (VALUE_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (n_idx),
        .o_rd_data (rd_data)
    );

    assign w_match     = (rd_data == r_val);
    assign w_last      = ((CW'(r_idx) + CW'(1)) == r_count);
    assign w_child_x   = XW'({r_idx, 1'b1});
    assign w_has_child = (w_child_x < XW'(r_count));
    assign w_climb     = (r_idx != '0) &&
                         (!r_idx[0] || ((CW'(r_idx) + CW'(1)) >= r_count));
    assign w_parent    = (r_idx - IW'(1)) >> 1;
    assign w_del_hit   = w_match ? r_idx : r_hit;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctvt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ctvt_pkg::S_DISPATCH;
                end
            end
            ctvt_pkg::S_DISPATCH: begin
                if ((r_cmd == ctvt_pkg::CMD_DELETE) && (r_count != '0)) begin
                    n_state = ctvt_pkg::S_DEL_SCAN;
                end else if ((r_cmd == ctvt_pkg::CMD_SEARCH) && (r_count != '0)) begin
                    n_state = ctvt_pkg::S_SRCH_CMP;
                end else begin
                    n_state = ctvt_pkg::S_DONE;
                end
            end
            ctvt_pkg::S_DEL_SCAN: begin
                if (w_last) begin
                    n_state = ctvt_pkg::S_DONE;
                end
            end
            ctvt_pkg::S_SRCH_CMP: begin
                if (w_match) begin
                    n_state = ctvt_pkg::S_DONE;
                end else if (!w_has_child) begin
                    n_state = ctvt_pkg::S_SRCH_UP;
                end
            end
            ctvt_pkg::S_SRCH_UP: begin
                if (!w_climb) begin
                    n_state = (r_idx == '0) ? ctvt_pkg::S_DONE : ctvt_pkg::S_SRCH_CMP;
                end
            end
            ctvt_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = ctvt_pkg::S_IDLE;
                end
            end
            default: n_state = ctvt_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_cmd        = r_cmd;
        n_val        = r_val;
        n_count      = r_count;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_found      = r_found;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        wr_en        = 1'b0;
        wr_addr      = w_del_hit;
        wr_data      = rd_data;
        unique case (r_state)
            ctvt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_cmd;
                    n_val = VALUE_WIDTH'(i_value);
                end
            end
            ctvt_pkg::S_DISPATCH: begin
                n_idx        = '0;
                n_found      = 1'b0;
                n_res_status = ctvt_pkg::ST_NOT_FOUND;
                n_res_pos    = '0;
                if (r_cmd == ctvt_pkg::CMD_INSERT) begin
                    if (r_count < CAP_C) begin
                        wr_en        = 1'b1;
                        wr_addr      = IW'(r_count);
                        wr_data      = r_val;
                        n_count      = r_count + CW'(1);
                        n_res_status = ctvt_pkg::ST_DONE;
                        n_res_pos    = IW'(r_count);
                    end else begin
                        n_res_status = ctvt_pkg::ST_FULL;
                    end
                end
            end
            ctvt_pkg::S_DEL_SCAN: begin
                n_idx = r_idx + IW'(1);
                if (w_match) begin
                    n_hit   = r_idx;
                    n_found = 1'b1;
                end
                if (w_last && (w_match || r_found)) begin
                    // last entry overwrites the last match
                    wr_en        = 1'b1;
                    n_count      = r_count - CW'(1);
                    n_res_status = ctvt_pkg::ST_DONE;
                    n_res_pos    = (r_count == CW'(1)) ? '0 : w_del_hit;
                end
            end
            ctvt_pkg::S_SRCH_CMP: begin
                if (w_match) begin
                    n_res_status = ctvt_pkg::ST_DONE;
                    n_res_pos    = r_idx;
                end else if (w_has_child) begin
                    n_idx = IW'(w_child_x);
                end
            end
            ctvt_pkg::S_SRCH_UP: begin
                if (w_climb) begin
                    n_idx = w_parent;
                end else if (r_idx != '0) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ctvt_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ctvt_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if ((r_state == ctvt_pkg::S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_hit        <= n_hit;
        r_found      <= n_found;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        if ((r_state == ctvt_pkg::S_DONE) && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_pos    <= r_res_pos;
            r_out_count  <= r_count;
        end
    end

    assign o_in_ready    = (r_state == ctvt_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_position    = PW'(r_out_pos);
    assign o_count_after = OW'(r_out_count);

endmodule

### rtl/ctvt_checker.sv
// ----------------------------------------------------------------------------
// ctvt_checker
// Port-level checks of the complete tree value table, bound to the top level.
// ----------------------------------------------------------------------------
`include "complete_tree_value_table_core_assert.svh"

module ctvt_checker #(
    parameter int CAPACITY = ctvt_pkg::DEF_CAPACITY
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_ready,
    input logic [ctvt_pkg::CMD_W-1:0]             i_cmd,
    input logic signed [ctvt_pkg::VALUE_IN_W-1:0] i_value,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic [ctvt_pkg::STATUS_W-1:0]          o_status,
    input logic [ctvt_pkg::POS_W-1:0]             o_position,
    input logic [ctvt_pkg::COUNT_W-1:0]           o_count_after
);

    localparam int FULL_COUNT_I = CAPACITY % (2 ** ctvt_pkg::COUNT_W);
    localparam logic [ctvt_pkg::COUNT_W-1:0] FULL_COUNT = FULL_COUNT_I[ctvt_pkg::COUNT_W-1:0];

    logic w_cmd_seen;
    assign w_cmd_seen = i_in_valid && (i_cmd != '0 || i_value != '0 || 1'b1);

    `CTVT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_position) && $stable(o_count_after), "result changed before transfer")
    `CTVT_ASSERT_NEXT(a_one_in_flight, w_cmd_seen && o_in_ready, !o_in_ready, "second command taken while busy")
    `CTVT_ASSERT_SAME(a_miss_pos, o_out_valid && (o_status != ctvt_pkg::ST_DONE), o_position == '0, "nonzero position without a hit")
    `CTVT_ASSERT_SAME(a_full_count, o_out_valid && (o_status == ctvt_pkg::ST_FULL), o_count_after == FULL_COUNT, "table full reported below capacity")

endmodule

bind complete_tree_value_table_core ctvt_checker #(.CAPACITY(CAPACITY)) u_ctvt_checker (.*);
